[rtl/core/csvf_pkg.sv]
// ----------------------------------------------------------------------------
// csvf_pkg
// Shared widths, register indexes, mode codes, configuration struct and
// saturation helpers for the cascaded state variable filter.
// ----------------------------------------------------------------------------
package csvf_pkg;

    localparam int SAMPLE_BITS           = 24;
    localparam int COEF_FRAC_BITS        = 24;
    localparam int ST_W                  = 40;
    localparam int COEF_W                = 30;
    localparam int G_W                   = 29;
    localparam int K_W                   = 26;
    localparam int DAMP_W                = 25;
    localparam int MODE_W                = 2;
    localparam int CUT_W                 = 16;
    localparam int LOWPASS_BYPASS_START  = 65208;
    localparam int HIGHPASS_BYPASS_START = 328;
    localparam int BLEND_WIDTH_LOG2      = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_G          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_K          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_DAMPING    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER_FOUR      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF_POSITION = 3'd5;

    localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOTCH    = 2'd3;

    localparam logic [G_W-1:0]    COEF_G_RESET    = '0;
    localparam logic [K_W-1:0]    COEF_K_RESET    = K_W'(1) << (K_W - 1);
    localparam logic [DAMP_W-1:0] COEF_DAMP_RESET = DAMP_W'(1) << (DAMP_W - 1);

    localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

    typedef struct packed {
        logic [G_W-1:0]    coef_g;
        logic [K_W-1:0]    coef_k;
        logic [DAMP_W-1:0] coef_damping;
        logic [MODE_W-1:0] filter_mode;
        logic              order_four;
        logic [CUT_W-1:0]  cutoff_position;
    } csvf_cfg_t;

    // Sign-extend a state value by two bits for sums of up to three terms.
    function automatic logic signed [ST_W+1:0] ext_st(input logic signed [ST_W-1:0] v);
        return {{2{v[ST_W-1]}}, v};
    endfunction

    // Clamp a widened sum back into the state range.
    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ST_W+1:0] v);
        logic fits;
        fits = (&v[ST_W+1:ST_W-1]) || !(|v[ST_W+1:ST_W-1]);
        if (fits)
            return v[ST_W-1:0];
        else if (v[ST_W+1])
            return ST_MIN;
        else
            return ST_MAX;
    endfunction

endpackage

[rtl/core/csvf_channels.sv]
// ----------------------------------------------------------------------------
// csvf channels
// Valid/ready channel interfaces for input samples, filtered results and
// configuration writes.
// ----------------------------------------------------------------------------
interface csvf_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [csvf_pkg::SAMPLE_BITS-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface csvf_result_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [csvf_pkg::SAMPLE_BITS-1:0]  sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface csvf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [csvf_pkg::CFG_INDEX_W-1:0]     index;
    logic [csvf_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/csvf_cfg.sv]
// ----------------------------------------------------------------------------
// csvf_cfg
// Configuration register file: coefficients, mode, order and cutoff.
// ----------------------------------------------------------------------------
module csvf_cfg (
    input  logic                clk,
    input  logic                rst_n,
    csvf_cfg_if.sink            cfg,
    output csvf_pkg::csvf_cfg_t regs
);

    csvf_pkg::csvf_cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.coef_g          <= csvf_pkg::COEF_G_RESET;
            regs_reg.coef_k          <= csvf_pkg::COEF_K_RESET;
            regs_reg.coef_damping    <= csvf_pkg::COEF_DAMP_RESET;
            regs_reg.filter_mode     <= csvf_pkg::MODE_LOWPASS;
            regs_reg.order_four      <= 1'b1;
            regs_reg.cutoff_position <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                csvf_pkg::REG_COEF_G:
                    regs_reg.coef_g <= cfg.data[csvf_pkg::G_W-1:0];
                csvf_pkg::REG_COEF_K:
                    regs_reg.coef_k <= cfg.data[csvf_pkg::K_W-1:0];
                csvf_pkg::REG_COEF_DAMPING:
                    regs_reg.coef_damping <= cfg.data[csvf_pkg::DAMP_W-1:0];
                csvf_pkg::REG_FILTER_MODE:
                    regs_reg.filter_mode <= cfg.data[csvf_pkg::MODE_W-1:0];
                csvf_pkg::REG_ORDER_FOUR:
                    regs_reg.order_four <= cfg.data[0];
                csvf_pkg::REG_CUTOFF_POSITION:
                    regs_reg.cutoff_position <= cfg.data[csvf_pkg::CUT_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

[rtl/core/csvf_mul.sv]
// ----------------------------------------------------------------------------
// csvf_mul
// Shared coefficient multiplier: signed state value times unsigned fixed
// point coefficient, rounded half away from zero and saturated. The state
// magnitude is multiplied in two slices, one after the other.
// ----------------------------------------------------------------------------
module csvf_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [csvf_pkg::ST_W-1:0]    operand,
    input  logic [csvf_pkg::COEF_W-1:0]         coef,
    output logic                                done,
    output logic signed [csvf_pkg::ST_W-1:0]    product
);

    localparam int ST_W   = csvf_pkg::ST_W;
    localparam int COEF_W = csvf_pkg::COEF_W;
    localparam int ACC_W  = ST_W + COEF_W;
    localparam int LO_W   = ST_W / 2;
    localparam int SL_W   = ST_W - LO_W;
    localparam int PP_W   = SL_W + COEF_W;
    localparam int R_W    = ACC_W - csvf_pkg::COEF_FRAC_BITS;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (csvf_pkg::COEF_FRAC_BITS - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ABS  = 2'd1;
    localparam logic [1:0] PH_LO   = 2'd2;
    localparam logic [1:0] PH_HI   = 2'd3;

    logic [1:0]              phase_reg;
    logic                    done_reg;
    logic signed [ST_W-1:0]  a_reg;
    logic [COEF_W-1:0]       c_reg;
    logic                    neg_reg;
    logic [ST_W-1:0]         mag_reg;
    logic [ACC_W-1:0]        acc_reg;

    logic [SL_W-1:0]  slice;
    logic [PP_W-1:0]  partial;
    logic [R_W-1:0]   rounded;
    logic             big;

    // Low slice first, high slice second.
    assign slice   = (phase_reg == PH_LO) ? SL_W'(mag_reg[LO_W-1:0]) : mag_reg[ST_W-1:LO_W];
    assign partial = PP_W'(slice) * PP_W'(c_reg);

    assign rounded = acc_reg[ACC_W-1:csvf_pkg::COEF_FRAC_BITS];
    assign big     = |rounded[R_W-1:ST_W-1];

    always_comb
    begin
        if (neg_reg)
            product = big ? csvf_pkg::ST_MIN : -rounded[ST_W-1:0];
        else
            product = big ? csvf_pkg::ST_MAX : rounded[ST_W-1:0];
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_HI);
            case (phase_reg)
                PH_IDLE: phase_reg <= start ? PH_ABS : PH_IDLE;
                PH_ABS:  phase_reg <= PH_LO;
                PH_LO:   phase_reg <= PH_HI;
                PH_HI:   phase_reg <= start ? PH_ABS : PH_IDLE;
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= operand;
            c_reg <= coef;
        end
        if (phase_reg == PH_ABS)
        begin
            neg_reg <= a_reg[ST_W-1];
            mag_reg <= a_reg[ST_W-1] ? -a_reg : a_reg;
        end
        if (phase_reg == PH_LO)
            acc_reg <= ACC_W'(partial) + ROUND;
        if (phase_reg == PH_HI)
            acc_reg <= acc_reg + {partial, {LO_W{1'b0}}};
    end

endmodule

[rtl/core/cascaded_state_variable_filter_core.sv]
// ----------------------------------------------------------------------------
// cascaded_state_variable_filter_core
// Zero-delay-feedback state variable filter, one or two cascaded sections,
// with a lowpass/highpass dry/wet crossfade near the ends of the cutoff range.
//
//   channel    role      fields                      accepted when
//   samples    sink      sample_in (24 b signed)     valid && ready
//   filtered   source    sample_out (24 b signed)    valid && ready
//   cfg        sink      index (3 b), data (32 b)    valid && ready
//
// Four coefficient multiplies per section go one after the other through the
// shared multiplier.
// samples.ready is high only while the sequencer is idle; a finished result
// waits in the output register and does not block the next accept.
// Reset clears the integrators and loads the register defaults at once.
// ----------------------------------------------------------------------------
module cascaded_state_variable_filter_core (
    input  logic            clk,
    input  logic            rst_n,
    csvf_cfg_if.sink        cfg,
    csvf_sample_if.sink     samples,
    csvf_result_if.source   filtered
);

    localparam int ST_W   = csvf_pkg::ST_W;
    localparam int SMP_W  = csvf_pkg::SAMPLE_BITS;
    localparam int COEF_W = csvf_pkg::COEF_W;
    localparam int CUT_W  = csvf_pkg::CUT_W;
    localparam int BW     = csvf_pkg::BLEND_WIDTH_LOG2;
    localparam int DIST_W = CUT_W + 2;
    localparam int PROD_W = ST_W + 1 + BW + 1;
    localparam int RES_W  = ST_W + 4;

    localparam logic [PROD_W-1:0] BLEND_ROUND = (PROD_W'(1) << BW) >> 1;
    localparam logic signed [DIST_W-1:0] LP_START =
        DIST_W'(csvf_pkg::LOWPASS_BYPASS_START);
    localparam logic signed [DIST_W-1:0] HP_START =
        DIST_W'(csvf_pkg::HIGHPASS_BYPASS_START);
    localparam logic signed [DIST_W-1:0] BLEND_FULL = DIST_W'(1) << BW;
    localparam logic signed [RES_W-1:0] SMP_MAX =
        RES_W'({1'b0, {(SMP_W-1){1'b1}}});
    localparam logic signed [RES_W-1:0] SMP_MIN = -SMP_MAX - RES_W'(1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_GK    = 4'd1;
    localparam logic [3:0] ST_HP    = 4'd2;
    localparam logic [3:0] ST_V1    = 4'd3;
    localparam logic [3:0] ST_V2    = 4'd4;
    localparam logic [3:0] ST_TAP   = 4'd5;
    localparam logic [3:0] ST_DIFF  = 4'd6;
    localparam logic [3:0] ST_SCALE = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    csvf_pkg::csvf_cfg_t regs;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic                    sec_reg;
    logic signed [SMP_W-1:0] x_reg;
    logic signed [ST_W-1:0]  sin_reg;
    logic signed [ST_W-1:0]  hp_reg;
    logic signed [ST_W-1:0]  bp_reg;
    logic signed [ST_W-1:0]  v1_reg;
    logic signed [ST_W-1:0]  v2_reg;
    logic signed [ST_W-1:0]  lp_reg;
    logic signed [ST_W-1:0]  y_reg;
    logic signed [ST_W-1:0]  band1_reg;
    logic signed [ST_W-1:0]  low1_reg;
    logic signed [ST_W-1:0]  band2_reg;
    logic signed [ST_W-1:0]  low2_reg;
    logic                    bneg_reg;
    logic [ST_W:0]           bmag_reg;
    logic [BW:0]             bd_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] out_sample_reg;

    logic                    mul_start;
    logic signed [ST_W-1:0]  mul_operand;
    logic [COEF_W-1:0]       mul_coef;
    logic                    mul_done;
    logic signed [ST_W-1:0]  mul_product;

    logic signed [ST_W-1:0]  band_cur;
    logic signed [ST_W-1:0]  low_cur;
    logic [COEF_W-1:0]       coef_gk;
    logic signed [ST_W-1:0]  x_ext;
    logic signed [ST_W-1:0]  u_val;
    logic signed [ST_W-1:0]  bp_val;
    logic signed [ST_W-1:0]  band_new;
    logic signed [ST_W-1:0]  lp_val;
    logic signed [ST_W-1:0]  low_new;
    logic signed [ST_W-1:0]  tap_val;
    logic                    chain_second;
    logic signed [ST_W:0]    blend_diff;
    logic signed [DIST_W-1:0] dist_raw;
    logic [BW:0]             blend_d;
    logic [ST_W+1:0]         scaled;
    logic signed [RES_W-1:0] blend_res;
    logic signed [SMP_W-1:0] out_val;
    logic                    out_free;

    csvf_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    csvf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .coef    (mul_coef),
        .done    (mul_done),
        .product (mul_product)
    );

    assign samples.ready   = (state_reg == ST_IDLE);
    assign filtered.valid  = out_valid_reg;
    assign filtered.sample_out = out_sample_reg;

    assign band_cur = sec_reg ? band2_reg : band1_reg;
    assign low_cur  = sec_reg ? low2_reg : low1_reg;
    assign coef_gk  = COEF_W'(regs.coef_g) + COEF_W'(regs.coef_k);
    assign x_ext    = {{(ST_W-SMP_W){samples.sample_in[SMP_W-1]}}, samples.sample_in};

    assign u_val    = csvf_pkg::sat_st(csvf_pkg::ext_st(sin_reg)
                                       - csvf_pkg::ext_st(mul_product)
                                       - csvf_pkg::ext_st(low_cur));
    assign bp_val   = csvf_pkg::sat_st(csvf_pkg::ext_st(mul_product)
                                       + csvf_pkg::ext_st(band_cur));
    assign band_new = csvf_pkg::sat_st(csvf_pkg::ext_st(v1_reg) + csvf_pkg::ext_st(bp_reg));
    assign lp_val   = csvf_pkg::sat_st(csvf_pkg::ext_st(mul_product)
                                       + csvf_pkg::ext_st(low_cur));
    assign low_new  = csvf_pkg::sat_st(csvf_pkg::ext_st(v2_reg) + csvf_pkg::ext_st(lp_reg));

    always_comb
    begin
        case (regs.filter_mode)
            csvf_pkg::MODE_LOWPASS:  tap_val = lp_reg;
            csvf_pkg::MODE_HIGHPASS: tap_val = hp_reg;
            csvf_pkg::MODE_BANDPASS: tap_val = bp_reg;
            default:
                tap_val = csvf_pkg::sat_st(csvf_pkg::ext_st(lp_reg)
                                           + csvf_pkg::ext_st(hp_reg));
        endcase
    end

    assign chain_second = !sec_reg && regs.order_four;

    // Crossfade depth from the cutoff position
    always_comb
    begin
        case (regs.filter_mode)
            csvf_pkg::MODE_LOWPASS:
                dist_raw = LP_START - $signed({2'b00, regs.cutoff_position});
            csvf_pkg::MODE_HIGHPASS:
                dist_raw = $signed({2'b00, regs.cutoff_position}) - HP_START;
            default:
                dist_raw = BLEND_FULL;
        endcase
        if (dist_raw < 0)
            blend_d = '0;
        else if (dist_raw > BLEND_FULL)
            blend_d = BLEND_FULL[BW:0];
        else
            blend_d = dist_raw[BW:0];
    end

    assign blend_diff = {y_reg[ST_W-1], y_reg}
                        - {{(ST_W+1-SMP_W){x_reg[SMP_W-1]}}, x_reg};
    assign scaled     = prod_reg[PROD_W-1:BW];

    always_comb
    begin
        blend_res = {{(RES_W-SMP_W){x_reg[SMP_W-1]}}, x_reg};
        if (bneg_reg)
            blend_res = blend_res - $signed({2'b00, scaled});
        else
            blend_res = blend_res + $signed({2'b00, scaled});
        if (blend_res > SMP_MAX)
            out_val = SMP_MAX[SMP_W-1:0];
        else if (blend_res < SMP_MIN)
            out_val = SMP_MIN[SMP_W-1:0];
        else
            out_val = blend_res[SMP_W-1:0];
    end

    assign out_free = !out_valid_reg || filtered.ready;

    // Sequencer: feed the shared multiplier and advance on its done pulse in the multiply states
    always_comb
    begin
        state_next  = state_reg;
        mul_start   = 1'b0;
        mul_operand = band1_reg;
        mul_coef    = coef_gk;
        case (state_reg)
            ST_IDLE:
            begin
                mul_start = samples.valid;
                if (samples.valid)
                    state_next = ST_GK;
            end
            ST_GK:
            begin
                mul_start   = mul_done;
                mul_operand = u_val;
                mul_coef    = COEF_W'(regs.coef_damping);
                if (mul_done)
                    state_next = ST_HP;
            end
            ST_HP:
            begin
                mul_start   = mul_done;
                mul_operand = mul_product;
                mul_coef    = COEF_W'(regs.coef_g);
                if (mul_done)
                    state_next = ST_V1;
            end
            ST_V1:
            begin
                mul_start   = mul_done;
                mul_operand = bp_val;
                mul_coef    = COEF_W'(regs.coef_g);
                if (mul_done)
                    state_next = ST_V2;
            end
            ST_V2:
            begin
                if (mul_done)
                    state_next = ST_TAP;
            end
            ST_TAP:
            begin
                mul_start   = chain_second;
                mul_operand = band2_reg;
                state_next  = chain_second ? ST_GK : ST_DIFF;
            end
            ST_DIFF:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            band1_reg     <= '0;
            low1_reg      <= '0;
            band2_reg     <= '0;
            low2_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_TAP)
                sec_reg <= chain_second;
            if (state_reg == ST_V2 && mul_done)
            begin
                if (sec_reg)
                    band2_reg <= band_new;
                else
                    band1_reg <= band_new;
            end
            if (state_reg == ST_TAP)
            begin
                if (sec_reg)
                    low2_reg <= low_new;
                else
                    low1_reg <= low_new;
            end
            // Drop the held item once taken; load a new one when free
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (filtered.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && samples.valid)
        begin
            x_reg   <= samples.sample_in;
            sin_reg <= x_ext;
        end
        if (state_reg == ST_HP && mul_done)
            hp_reg <= mul_product;
        if (state_reg == ST_V1 && mul_done)
        begin
            bp_reg <= bp_val;
            v1_reg <= mul_product;
        end
        if (state_reg == ST_V2 && mul_done)
        begin
            lp_reg <= lp_val;
            v2_reg <= mul_product;
        end
        if (state_reg == ST_TAP)
        begin
            sin_reg <= tap_val;
            y_reg   <= tap_val;
        end
        if (state_reg == ST_DIFF)
        begin
            bneg_reg <= blend_diff[ST_W];
            bmag_reg <= blend_diff[ST_W] ? -blend_diff : blend_diff;
            bd_reg   <= blend_d;
        end
        if (state_reg == ST_SCALE)
            prod_reg <= PROD_W'(bmag_reg) * PROD_W'(bd_reg) + BLEND_ROUND;
        if (state_reg == ST_OUT && out_free)
            out_sample_reg <= out_val;
    end

endmodule
